// ===== rtl/spiral_order_matrix_reader_assert.svh =====
// ----------------------------------------------------------------------------
// Spiral order matrix reader - assertion macros
// Shared concurrent assertion forms for the spiral reader RTL.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_ORDER_MATRIX_READER_ASSERT_SVH
`define SPIRAL_ORDER_MATRIX_READER_ASSERT_SVH

// Same-cycle implication, masked while reset is held
`define SMR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spiral reader: same-cycle check failed");

// Next-cycle implication, masked while reset is held
`define SMR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spiral reader: next-cycle check failed");

`endif

// ===== rtl/smr_pkg.sv =====
// ----------------------------------------------------------------------------
// Spiral order matrix reader - package
// Sizes, codes, state and heading types, and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package smr_pkg;

    // Matrix geometry and word width
    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_W     = 32;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
    localparam int COL_IDX_W  = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_IDX_W + COL_IDX_W;
    localparam int POS_W      = $clog2(DEPTH + 1);

    // Size registers
    localparam int CNT_W      = 5;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(4);
    localparam logic [CNT_W-1:0] ROWS_LIMIT  = CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] COLS_LIMIT  = CNT_W'(MAX_COLS);

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Walk heading
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_CHK,
        ST_DIV,
        ST_LOAD_WR,
        ST_EMIT_CHK,
        ST_EMIT_RD,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_begin;
        logic div_start;
        logic div_step;
        logic load_wr;
        logic walk_begin;
        logic emit_rd;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_needed;
        logic div_last;
        logic walk_done;
    } dp_stat_t;

    // Zero counts as one, anything above the maximum as the maximum
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/smr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Spiral order matrix reader - controller
// Sequences one item at a time through load, divide, read and output steps.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic            s_tuser,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output smr_pkg::dp_cmd_t     cmd,
    input  wire smr_pkg::dp_stat_t stat
);
    import smr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? ST_EMIT_CHK : ST_LOAD_CHK;
                end
            end
            ST_LOAD_CHK: begin
                state_next = stat.div_needed ? ST_DIV : ST_LOAD_WR;
            end
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_LOAD_WR;
                end
            end
            ST_LOAD_WR:  state_next = ST_IDLE;
            ST_EMIT_CHK: state_next = ST_EMIT_RD;
            ST_EMIT_RD: begin
                state_next = stat.walk_done ? ST_IDLE : ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD_CHK: begin
                cmd.load_begin = 1'b1;
                cmd.div_start  = stat.div_needed;
            end
            ST_DIV:      cmd.div_step   = 1'b1;
            ST_LOAD_WR:  cmd.load_wr    = 1'b1;
            ST_EMIT_CHK: cmd.walk_begin = 1'b1;
            ST_EMIT_RD:  cmd.emit_rd    = 1'b1;
            ST_OUT:      m_tvalid       = 1'b1;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/smr_datapath.sv =====
// ----------------------------------------------------------------------------
// Spiral order matrix reader - datapath
// Size registers, matrix store, row-major load counters with a divider for
// size changes, and the spiral walk with its four shrinking limits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spiral_order_matrix_reader_assert.svh"

module smr_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [smr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [smr_pkg::CNT_W-1:0]       cfg_wdata,
    input  wire logic [smr_pkg::DATA_W-1:0]      in_value,
    input  wire smr_pkg::dp_cmd_t                cmd,
    output smr_pkg::dp_stat_t                    stat,
    output logic [smr_pkg::DATA_W-1:0]           out_value,
    output logic                                 out_final
);
    import smr_pkg::*;

    // Size registers
    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] col_count_reg;
    logic [CNT_W-1:0] crows;
    logic [CNT_W-1:0] ccols;

    // Load side
    logic [DATA_W-1:0] item_val_reg;
    logic [POS_W-1:0]  load_pos_reg;
    logic [POS_W-1:0]  ld_row_reg;
    logic [CNT_W-1:0]  ld_col_reg;
    logic [CNT_W-1:0]  cache_cols_reg;
    logic [POS_W-1:0]  load_total;
    logic              room;
    logic              wr_en;
    logic              cols_match;

    // Divider
    logic [POS_W-1:0]     div_quo_reg;
    logic [CNT_W-1:0]     div_rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_next;
    logic [POS_W-1:0]     quo_next;
    logic                 quo_bit;
    logic                 div_last;

    // Walk side
    logic             emitting_reg;
    logic [POS_W-1:0] emit_cnt_reg;
    logic [POS_W-1:0] walk_total_reg;
    logic [CNT_W-1:0] cur_row_reg, cur_row_next;
    logic [CNT_W-1:0] cur_col_reg, cur_col_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] right_reg, right_next;
    logic [CNT_W-1:0] upper_reg, upper_next;
    logic [CNT_W-1:0] lower_reg, lower_next;
    dir_t             heading_reg, heading_next;
    logic             walk_done;
    logic             rd_en;
    logic             final_reg;

    // Store
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Take register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= RESET_COUNT;
            col_count_reg <= RESET_COUNT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ROW_COUNT:    row_count_reg <= cfg_wdata;
                CFG_COLUMN_COUNT: col_count_reg <= cfg_wdata;
            endcase
        end
    end

    assign crows = clamp_count(row_count_reg, ROWS_LIMIT);
    assign ccols = clamp_count(col_count_reg, COLS_LIMIT);

    // Hold the element of the current item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_val_reg <= in_value;
        end
    end

    // Load bookkeeping; the row/column split is valid for cache_cols_reg
    assign load_total = POS_W'(crows) * POS_W'(ccols);
    assign room       = load_pos_reg < load_total;
    assign wr_en      = cmd.load_wr && room;
    assign cols_match = cache_cols_reg == ccols;

    // One restoring division step
    assign rem_sh   = {div_rem_reg, div_quo_reg[POS_W-1]};
    assign quo_bit  = rem_sh >= {1'b0, ccols};
    assign rem_next = quo_bit ? (rem_sh - {1'b0, ccols}) : rem_sh;
    assign quo_next = {div_quo_reg[POS_W-2:0], quo_bit};
    assign div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_quo_reg <= load_pos_reg;
            div_rem_reg <= '0;
        end else if (cmd.div_step) begin
            div_quo_reg <= quo_next;
            div_rem_reg <= rem_next[CNT_W-1:0];
        end
    end

    // Advance the load position, restart it after emission, or resplit it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg   <= '0;
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            cache_cols_reg <= RESET_COUNT;
        end else if (cmd.load_begin && emitting_reg) begin
            load_pos_reg   <= '0;
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            cache_cols_reg <= ccols;
        end else if (cmd.div_step && div_last) begin
            ld_row_reg     <= quo_next;
            ld_col_reg     <= rem_next[CNT_W-1:0];
            cache_cols_reg <= ccols;
        end else if (wr_en) begin
            load_pos_reg <= load_pos_reg + POS_W'(1);
            if (ld_col_reg == ccols - CNT_W'(1)) begin
                ld_col_reg <= '0;
                ld_row_reg <= ld_row_reg + POS_W'(1);
            end else begin
                ld_col_reg <= ld_col_reg + CNT_W'(1);
            end
        end
    end

    // Next spiral position: step on, or turn at a limit and pull it in
    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        heading_next = heading_reg;
        unique case (heading_reg)
            DIR_RIGHT: begin
                if (cur_col_reg == right_reg) begin
                    right_next   = right_reg - CNT_W'(1);
                    cur_row_next = cur_row_reg + CNT_W'(1);
                    heading_next = DIR_DOWN;
                end else begin
                    cur_col_next = cur_col_reg + CNT_W'(1);
                end
            end
            DIR_DOWN: begin
                if (cur_row_reg == lower_reg) begin
                    lower_next   = lower_reg - CNT_W'(1);
                    cur_col_next = cur_col_reg - CNT_W'(1);
                    heading_next = DIR_LEFT;
                end else begin
                    cur_row_next = cur_row_reg + CNT_W'(1);
                end
            end
            DIR_LEFT: begin
                if (cur_col_reg == left_reg) begin
                    left_next    = left_reg + CNT_W'(1);
                    cur_row_next = cur_row_reg - CNT_W'(1);
                    heading_next = DIR_UP;
                end else begin
                    cur_col_next = cur_col_reg - CNT_W'(1);
                end
            end
            DIR_UP: begin
                if (cur_row_reg == upper_reg) begin
                    upper_next   = upper_reg + CNT_W'(1);
                    cur_col_next = cur_col_reg + CNT_W'(1);
                    heading_next = DIR_RIGHT;
                end else begin
                    cur_row_next = cur_row_reg - CNT_W'(1);
                end
            end
        endcase
    end

    assign walk_done = emit_cnt_reg >= walk_total_reg;
    assign rd_en     = cmd.emit_rd && !walk_done;

    // Start, end or step the walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emitting_reg   <= 1'b0;
            emit_cnt_reg   <= '0;
            walk_total_reg <= POS_W'(RESET_COUNT) * POS_W'(RESET_COUNT);
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            heading_reg    <= DIR_RIGHT;
            left_reg       <= '0;
            right_reg      <= RESET_COUNT - CNT_W'(1);
            upper_reg      <= CNT_W'(1);
            lower_reg      <= RESET_COUNT - CNT_W'(1);
        end else if (cmd.walk_begin && !emitting_reg) begin
            emitting_reg   <= 1'b1;
            emit_cnt_reg   <= '0;
            walk_total_reg <= load_total;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            heading_reg    <= DIR_RIGHT;
            left_reg       <= '0;
            right_reg      <= ccols - CNT_W'(1);
            upper_reg      <= CNT_W'(1);
            lower_reg      <= crows - CNT_W'(1);
        end else if (cmd.load_begin && emitting_reg) begin
            emitting_reg <= 1'b0;
        end else if (rd_en) begin
            emit_cnt_reg <= emit_cnt_reg + POS_W'(1);
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            heading_reg  <= heading_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            upper_reg    <= upper_next;
            lower_reg    <= lower_next;
        end
    end

    // Flag the last element along with its read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            final_reg <= (emit_cnt_reg + POS_W'(1)) == walk_total_reg;
        end
    end

    // Matrix store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{ld_row_reg[ROW_IDX_W-1:0], ld_col_reg[COL_IDX_W-1:0]}] <= item_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[{cur_row_reg[ROW_IDX_W-1:0], cur_col_reg[COL_IDX_W-1:0]}];
        end
    end

    assign out_value = rd_data_reg;
    assign out_final = final_reg;

    assign stat.div_needed = !emitting_reg && !cols_match;
    assign stat.div_last   = div_last;
    assign stat.walk_done  = walk_done;

    // A store write always lands inside the matrix in use
    `SMR_ASSERT_IMPL(a_store_in_range, aclk, aresetn, wr_en, (ld_row_reg < POS_W'(crows)) && (ld_col_reg < ccols))
    // The last-element flag tracks the walk count
    `SMR_ASSERT_NEXT(a_final_flag, aclk, aresetn, rd_en, out_final == (emit_cnt_reg == walk_total_reg))
    // The walk never reads more elements than the matrix holds
    `SMR_ASSERT_IMPL(a_no_overrun, aclk, aresetn, 1'b1, emit_cnt_reg <= walk_total_reg)

endmodule

`default_nettype wire

// ===== rtl/spiral_order_matrix_reader.sv =====
// Load item: check and write states follow acceptance, then ready again; when the
//   column count changed since the last split, the restoring divider runs between them.
// Emit item: result valid after the check and read states; ready again in the cycle
//   after the result is taken. One store read; no result once the spiral is complete.
// Reset (aresetn, synchronous, active low) clears control and counters; no clearing pass.
// ----------------------------------------------------------------------------
// Spiral order matrix reader - top level
// Loads a matrix row-major and streams it back in clockwise spiral order.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_order_matrix_reader (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [smr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [smr_pkg::CNT_W-1:0]       cfg_wdata,
    // input channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [smr_pkg::DATA_W-1:0]      s_tdata,  // [31:0] element_value
    input  wire logic                            s_tuser,  // [0] action
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [smr_pkg::DATA_W-1:0]           m_tdata,  // [31:0] out_value
    output logic                                 m_tlast   // is_final
);
    import smr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    smr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    smr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_value  (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_value (m_tdata),
        .out_final (m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/spiral_order_matrix_reader_test.sv =====
// ----------------------------------------------------------------------------
// Spiral order matrix reader - testbench
// Loads matrices of many sizes row-major and reads them back in clockwise
// spiral order. Every word and end flag is checked against an in-bench model
// of the store and the walk. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_test;
    import smr_pkg::*;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] value;
    } matrix_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } spiral_word_t;

    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_EMIT      = 1'b1;
    localparam int   ITEM_TARGET   = 950;
    localparam int   SETTLE_CYCLES = 30;
    localparam int   LONG_HOLD     = 300;
    localparam int   DRAIN_LIMIT   = 4000;
    localparam int   WALK_CAP      = 48;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CNT_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // [31:0] element_value
    logic                  s_tuser   = 1'b0; // [0] action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // [31:0] out_value
    logic                  m_tlast;          // is_final

    // Items waiting to be offered, and spiral words still due out
    matrix_item_t pending_items[$];
    spiral_word_t words_due[$];
    matrix_item_t offered;
    int           items_queued  = 0;
    int           items_taken   = 0;
    int           mismatches    = 0;
    int           send_wait     = 0;
    int           take_wait     = 0;
    int           hold_requests = 0;
    int           hold_served   = 0;
    int           hold_left     = 0;
    logic         calm          = 1'b0;

    // Model of the store, the size registers and the walk
    logic [DATA_W-1:0] shadow_matrix [DEPTH];
    logic [CNT_W-1:0]  row_reg = RESET_COUNT;
    logic [CNT_W-1:0]  col_reg = RESET_COUNT;
    logic [POS_W-1:0]  fill_pos = '0;
    logic [POS_W-1:0]  walk_emitted = '0;
    logic [CNT_W-1:0]  walk_rows, walk_cols, at_row, at_col;
    logic [CNT_W-1:0]  lim_left, lim_right, lim_top, lim_bottom;
    dir_t              heading;
    logic              walking = 1'b0;

    spiral_order_matrix_reader DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // A count of zero acts as one, anything past the maximum as the maximum
    function automatic logic [CNT_W-1:0] used_count(input logic [CNT_W-1:0] v,
                                                    input int maxv);
        if (v == '0) return CNT_W'(1);
        if (int'(v) > maxv) return CNT_W'(maxv);
        return v;
    endfunction

    function automatic int pick_wait();
        if (calm) return 0;
        return $urandom_range(0, 8);
    endfunction

    // Mostly small sizes, with zero, the maximum and out-of-range values mixed in
    function automatic logic [CNT_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return CNT_W'($urandom_range(1, 5));
        if (r == 6) return '0;
        if (r == 7) return CNT_W'($urandom_range(17, 31));
        if (r == 8) return CNT_W'(16);
        return CNT_W'($urandom_range(6, 15));
    endfunction

    // Latch the walk size and go back to the top-left corner
    task automatic start_spiral();
        walk_rows    = used_count(row_reg, MAX_ROWS);
        walk_cols    = used_count(col_reg, MAX_COLS);
        walk_emitted = '0;
        at_row       = '0;
        at_col       = '0;
        heading      = DIR_RIGHT;
        lim_left     = '0;
        lim_right    = walk_cols - 1'b1;
        lim_top      = CNT_W'(1);
        lim_bottom   = walk_rows - 1'b1;
    endtask

    // Move one step clockwise, turning and shrinking a limit at each edge
    task automatic step_heading();
        case (heading)
            DIR_RIGHT: begin
                if (at_col == lim_right) begin
                    lim_right = lim_right - 1'b1;
                    at_row    = at_row + 1'b1;
                    heading   = DIR_DOWN;
                end else begin
                    at_col = at_col + 1'b1;
                end
            end
            DIR_DOWN: begin
                if (at_row == lim_bottom) begin
                    lim_bottom = lim_bottom - 1'b1;
                    at_col     = at_col - 1'b1;
                    heading    = DIR_LEFT;
                end else begin
                    at_row = at_row + 1'b1;
                end
            end
            DIR_LEFT: begin
                if (at_col == lim_left) begin
                    lim_left = lim_left + 1'b1;
                    at_row   = at_row - 1'b1;
                    heading  = DIR_UP;
                end else begin
                    at_col = at_col - 1'b1;
                end
            end
            default: begin
                if (at_row == lim_top) begin
                    lim_top = lim_top + 1'b1;
                    at_col  = at_col + 1'b1;
                    heading = DIR_RIGHT;
                end else begin
                    at_row = at_row - 1'b1;
                end
            end
        endcase
    endtask

    // Apply one accepted item to the model; emits queue the word they produce
    task automatic follow_item(input matrix_item_t it);
        logic [POS_W-1:0] rows, cols, total;
        spiral_word_t     w;
        int               idx;
        rows = POS_W'(used_count(row_reg, MAX_ROWS));
        cols = POS_W'(used_count(col_reg, MAX_COLS));
        if (it.action == ACT_LOAD) begin
            // a load after emission has begun restarts the load and ends the walk
            if (walking) begin
                walking  = 1'b0;
                fill_pos = '0;
                start_spiral();
            end
            // drop loads past the end of the matrix
            if (fill_pos < rows * cols) begin
                idx = int'(fill_pos / cols) * MAX_COLS + int'(fill_pos % cols);
                shadow_matrix[idx] = it.value;
                fill_pos = fill_pos + 1'b1;
            end
        end else begin
            if (!walking) begin
                walking = 1'b1;
                start_spiral();
            end
            total = POS_W'(walk_rows) * POS_W'(walk_cols);
            // nothing comes out once the spiral is complete
            if (walk_emitted < total) begin
                idx          = int'(at_row) * MAX_COLS + int'(at_col);
                w.value      = shadow_matrix[idx];
                walk_emitted = walk_emitted + 1'b1;
                w.last       = (walk_emitted == total);
                words_due.insert(words_due.size(), w);
                step_heading();
            end
        end
    endtask

    // Offer items from the pending queue, with a random gap before each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                follow_item(offered);
                items_taken++;
                send_wait = pick_wait();
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.value;
                    s_tuser  <= offered.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Take results, compare with the oldest word due, and stall at random
    always @(posedge aclk) begin
        spiral_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected result: out_value %h, is_final %b", m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = words_due.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("out_value: expected %h, got %h", want.value, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("is_final: expected %b, got %b", want.last, m_tlast);
                        mismatches++;
                    end
                end
                take_wait = pick_wait();
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (take_wait != 0) begin
                take_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_size(input logic [CFG_ADDR_W-1:0] index,
                              input logic [CNT_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        if (index == CFG_ROW_COUNT) begin
            row_reg <= value;
        end else begin
            col_reg <= value;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_run(input logic action, input int count);
        matrix_item_t it;
        repeat (count) begin
            it.action = action;
            it.value  = $urandom();
            pending_items.insert(pending_items.size(), it);
            items_queued++;
        end
    endtask

    // Wait for every item to be taken and every word to come out, then settle
    task automatic drain();
        int spent;
        spent = 0;
        while (items_taken != items_queued) @(posedge aclk);
        while (words_due.size() != 0 && spent < DRAIN_LIMIT) begin
            @(posedge aclk);
            spent++;
        end
        if (words_due.size() != 0) begin
            $error("out_value: %0d results never came, oldest expected %h",
                   words_due.size(), words_due[0].value);
            mismatches++;
            words_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [DATA_W-1:0] corner_vals [12];
        logic [CNT_W-1:0]  rows_set, cols_set;
        int                total, kind, part;
        corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                        32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFE,
                        32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h8765_4321};
        start_spiral();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill the whole store once so that no walk can read an unwritten entry
        rows_set = CNT_W'(MAX_ROWS);
        cols_set = CNT_W'(MAX_COLS);
        write_size(CFG_ROW_COUNT, rows_set);
        write_size(CFG_COLUMN_COUNT, cols_set);
        queue_run(ACT_LOAD, DEPTH);
        drain();

        // Extreme values in a 3x4 matrix, read out and one emit past the end
        rows_set = CNT_W'(3);
        cols_set = CNT_W'(4);
        write_size(CFG_ROW_COUNT, rows_set);
        write_size(CFG_COLUMN_COUNT, cols_set);
        for (int i = 0; i < 12; i++) begin
            pending_items.insert(pending_items.size(),
                                 matrix_item_t'{action: ACT_LOAD, value: corner_vals[i]});
            items_queued++;
        end
        queue_run(ACT_EMIT, 13);
        drain();

        // Hold off the result side while the sender keeps offering
        @(posedge aclk);
        hold_requests <= hold_requests + 1;
        queue_run(ACT_LOAD, 12);
        queue_run(ACT_EMIT, 13);
        drain();

        // Random phases: mostly whole load-then-read sequences
        while (items_queued < ITEM_TARGET) begin
            @(posedge aclk);
            calm <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                part = $urandom_range(0, 2);
                if (part != 2) rows_set = pick_size();
                if (part != 1) cols_set = pick_size();
                if (int'(used_count(rows_set, MAX_ROWS)) *
                    int'(used_count(cols_set, MAX_COLS)) > WALK_CAP) begin
                    cols_set = CNT_W'($urandom_range(1, 3));
                    part     = 0;
                end
                if (part != 2) write_size(CFG_ROW_COUNT, rows_set);
                if (part != 1) write_size(CFG_COLUMN_COUNT, cols_set);
            end
            total = int'(used_count(rows_set, MAX_ROWS)) * int'(used_count(cols_set, MAX_COLS));
            kind  = $urandom_range(0, 9);
            if (kind < 6) begin
                queue_run(ACT_LOAD, total);
                queue_run(ACT_EMIT, total + $urandom_range(0, 1));
            end else if (kind == 6) begin
                // partial load, then a partial or complete read
                queue_run(ACT_LOAD, $urandom_range(0, total));
                queue_run(ACT_EMIT, $urandom_range(1, total + 1));
            end else if (kind == 7) begin
                // loads past the end of the matrix
                queue_run(ACT_LOAD, total + $urandom_range(1, 4));
                queue_run(ACT_EMIT, total);
            end else if (kind == 8) begin
                // break into a walk with a fresh load
                queue_run(ACT_LOAD, total);
                queue_run(ACT_EMIT, $urandom_range(1, total));
                queue_run(ACT_LOAD, $urandom_range(1, total));
                queue_run(ACT_EMIT, $urandom_range(1, total + 1));
            end else begin
                repeat ($urandom_range(8, 24)) queue_run(1'($urandom_range(0, 1)), 1);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("spiral_order_matrix_reader: match");
        end else begin
            $display("spiral_order_matrix_reader: mismatch");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #3000000;
        $display("spiral_order_matrix_reader: mismatch");
        $finish;
    end

endmodule

// ===== spiral_order_matrix_reader.f =====
+incdir+rtl
rtl/smr_pkg.sv
rtl/smr_ctrl.sv
rtl/smr_datapath.sv
rtl/spiral_order_matrix_reader.sv
bench/spiral_order_matrix_reader_test.sv
